/* hw/rtl/sit_pkg.sv */
`default_nettype none

package sit_pkg;

  // Timing constants of the slot scheme.
  localparam int MS_PER_S     = 1000;
  localparam int IVL_PER_SLOT = 5;
  localparam int MS_PER_IVL   = MS_PER_S / IVL_PER_SLOT;
  localparam int DEF_SPS      = 4;

  // Widths of the datapath.
  localparam int TIME_W    = 64;
  localparam int GEN_W     = 42;  // genesis seconds times 1000
  localparam int REM_W     = 26;  // holds a slot length in ms for any 16-bit slot length
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // One quotient bit per cell.
  localparam int DIV_STAGES = TIME_W;

  // Multiples of the interval length that are compared against the slot remainder.
  localparam int NUM_MULT = IVL_PER_SLOT - 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GENESIS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN = 2'd1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EARLY = 2'd1,
    ST_OVFL  = 2'd2
  } sit_status_t;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              vld;
    logic              early;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] qd;   // dividend bits shift out at the top, quotient bits in at the bottom
    logic [REM_W-1:0]  rem;
  } sit_cell_t;

  // One finished result.
  typedef struct packed {
    sit_status_t       status;
    logic [TIME_W-1:0] slot_number;
    logic [IDX_W-1:0]  ivl_idx;
    logic [TIME_W-1:0] slot_start_ms;
    logic [TIME_W-1:0] interval_start_ms;
    logic [TIME_W-1:0] interval_end_ms;
  } sit_result_t;

endpackage

`default_nettype wire

/* hw/rtl/slot_interval_timepoint.sv */
// An input passes the entry register, the 64 divider cells, the f1 and f2 registers
// and the output register; one timestamp per cycle unless the output is stalled.
// An entry register takes one more item while the output register is stalled.
// Reset (synchronous, rst_n low) empties the pipeline and loads genesis 0 and a 4 s slot.
`default_nettype none

module slot_interval_timepoint (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sit_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [63:0]                   in_now_ms,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [63:0]                        out_slot_number,
  output logic [2:0]                         out_interval_index,
  output logic [2:0]                         out_duty_phase,
  output logic [63:0]                        out_slot_start_ms,
  output logic [63:0]                        out_interval_start_ms,
  output logic [63:0]                        out_interval_end_ms
);
  import sit_pkg::*;

  logic [GEN_W-1:0]  genesis_ms_r;
  logic [REM_W-1:0]  slot_ms_r;
  logic [REM_W-1:0]  ivl_mul_r [NUM_MULT];
  logic [15:0]       sps_wr;
  logic              adv;
  logic              in_acc;
  logic [TIME_W:0]   elapsed;
  sit_cell_t         s0_r;
  sit_cell_t         chain [DIV_STAGES+1];
  logic              res_vld;
  sit_result_t       res;

  // Configuration: store genesis and slot length already scaled to milliseconds.
  assign sps_wr = cfg_wdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      genesis_ms_r <= '0;
      slot_ms_r    <= REM_W'(DEF_SPS * MS_PER_S);
      for (int k = 0; k < NUM_MULT; k++) begin
        ivl_mul_r[k] <= REM_W'(DEF_SPS * MS_PER_IVL * (k + 1));
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_GENESIS) begin
        genesis_ms_r <= {10'd0, cfg_wdata} * GEN_W'(MS_PER_S);
      end else if (cfg_index == CFG_SLOT_LEN && sps_wr != 16'd0) begin
        // A zero slot length is ignored.
        slot_ms_r <= {10'd0, sps_wr} * REM_W'(MS_PER_S);
        for (int k = 0; k < NUM_MULT; k++) begin
          ivl_mul_r[k] <= {10'd0, sps_wr} * REM_W'(MS_PER_IVL * (k + 1));
        end
      end
    end
  end

  // The whole pipeline moves unless a result waits on a stalled output.
  assign adv      = !(res_vld && out_stall);
  assign in_stall = s0_r.vld && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Entry stage: elapsed time since genesis; the borrow marks a time before genesis.
  assign elapsed = {1'b0, in_now_ms} - {{(TIME_W+1-GEN_W){1'b0}}, genesis_ms_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (in_acc) begin
      s0_r.vld   <= 1'b1;
      s0_r.early <= elapsed[TIME_W];
      s0_r.now   <= in_now_ms;
      s0_r.qd    <= elapsed[TIME_W-1:0];
      s0_r.rem   <= '0;
    end else if (adv) begin
      s0_r.vld <= 1'b0;
    end
  end

  // Divider chain: elapsed time over slot length, one quotient bit per cell.
  assign chain[0] = s0_r;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_cell
    sit_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .dvsr     (slot_ms_r),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // Interval split, start and end times, and the output register.
  sit_finish u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ivl_mul (ivl_mul_r),
    .div_in  (chain[DIV_STAGES]),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_valid             = res_vld;
  assign out_status            = res.status;
  assign out_slot_number       = res.slot_number;
  assign out_interval_index    = res.ivl_idx;
  assign out_duty_phase        = res.ivl_idx;
  assign out_slot_start_ms     = res.slot_start_ms;
  assign out_interval_start_ms = res.interval_start_ms;
  assign out_interval_end_ms   = res.interval_end_ms;

endmodule

`default_nettype wire

/* hw/rtl/sit_div_cell.sv */
`default_nettype none

module sit_div_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [sit_pkg::REM_W-1:0] dvsr,
  input  wire sit_pkg::sit_cell_t        cell_in,
  output sit_pkg::sit_cell_t             cell_out
);
  import sit_pkg::*;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              qbit;
  sit_cell_t         cell_nxt;
  sit_cell_t         cell_r;

  // Restoring division step: bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial    = {cell_in.rem, cell_in.qd[TIME_W-1]};
    diff     = trial - {1'b0, dvsr};
    qbit     = (trial >= {1'b0, dvsr});
    cell_nxt = cell_in;
    cell_nxt.qd  = {cell_in.qd[TIME_W-2:0], qbit};
    cell_nxt.rem = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
  end

  // Stage register; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

`default_nettype wire

/* hw/rtl/sit_finish.sv */
`default_nettype none

module sit_finish (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [sit_pkg::REM_W-1:0] ivl_mul [sit_pkg::NUM_MULT],
  input  wire sit_pkg::sit_cell_t        div_in,
  output logic                           res_vld,
  output sit_pkg::sit_result_t           res
);
  import sit_pkg::*;

  typedef struct packed {
    logic              vld;
    logic              early;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] slot_base;
    logic [REM_W-1:0]  off;
  } sit_f1_t;

  typedef struct packed {
    logic              vld;
    logic              early;
    logic [TIME_W-1:0] slot;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] slot_base;
    logic [TIME_W-1:0] ivl_start;
  } sit_f2_t;

  sit_f1_t          f1_nxt;
  sit_f1_t          f1_r;
  sit_f2_t          f2_nxt;
  sit_f2_t          f2_r;
  logic [REM_W-1:0] sub_sel;
  logic [TIME_W:0]  end_sum;
  sit_result_t      res_nxt;
  sit_result_t      res_r;
  logic             res_vld_r;

  // Interval index from the remainder within the slot, the offset into the interval, and the slot start.
  always_comb begin
    f1_nxt       = '0;
    f1_nxt.vld   = div_in.vld;
    f1_nxt.early = div_in.early;
    f1_nxt.now   = div_in.now;
    f1_nxt.slot  = div_in.qd;
    if (div_in.rem >= ivl_mul[3]) begin
      f1_nxt.idx = 3'd4;
    end else if (div_in.rem >= ivl_mul[2]) begin
      f1_nxt.idx = 3'd3;
    end else if (div_in.rem >= ivl_mul[1]) begin
      f1_nxt.idx = 3'd2;
    end else if (div_in.rem >= ivl_mul[0]) begin
      f1_nxt.idx = 3'd1;
    end else begin
      f1_nxt.idx = 3'd0;
    end
    case (f1_nxt.idx)
      3'd1:    sub_sel = ivl_mul[0];
      3'd2:    sub_sel = ivl_mul[1];
      3'd3:    sub_sel = ivl_mul[2];
      3'd4:    sub_sel = ivl_mul[3];
      default: sub_sel = '0;
    endcase
    f1_nxt.off       = div_in.rem - sub_sel;
    f1_nxt.slot_base = div_in.now - {{(TIME_W-REM_W){1'b0}}, div_in.rem};
  end

  // Interval start is the timestamp minus the offset into the interval.
  always_comb begin
    f2_nxt           = '0;
    f2_nxt.vld       = f1_r.vld;
    f2_nxt.early     = f1_r.early;
    f2_nxt.slot      = f1_r.slot;
    f2_nxt.idx       = f1_r.idx;
    f2_nxt.slot_base = f1_r.slot_base;
    f2_nxt.ivl_start = f1_r.now - {{(TIME_W-REM_W){1'b0}}, f1_r.off};
  end

  // Interval end with a carry out for the overflow check; error results carry zeros.
  always_comb begin
    end_sum = {1'b0, f2_r.ivl_start} + {{(TIME_W+1-REM_W){1'b0}}, ivl_mul[0]};
    res_nxt = '0;
    if (f2_r.early) begin
      res_nxt.status = ST_EARLY;
    end else if (end_sum[TIME_W]) begin
      res_nxt.status = ST_OVFL;
    end else begin
      res_nxt.status            = ST_OK;
      res_nxt.slot_number       = f2_r.slot;
      res_nxt.ivl_idx           = f2_r.idx;
      res_nxt.slot_start_ms     = f2_r.slot_base;
      res_nxt.interval_start_ms = f2_r.ivl_start;
      res_nxt.interval_end_ms   = end_sum[TIME_W-1:0];
    end
  end

  // Stage registers, the last one being the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.vld  <= 1'b0;
      f2_r.vld  <= 1'b0;
      res_vld_r <= 1'b0;
    end else if (adv) begin
      f1_r      <= f1_nxt;
      f2_r      <= f2_nxt;
      res_vld_r <= f2_r.vld;
      res_r     <= res_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

`default_nettype wire
